// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the dither RTL. They are compiled
// out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== sv/fsd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Floyd-Steinberg dither package
// Widths, constants and shared types of the binary error-diffusion dither.
// ---------------------------------------------------------------------------
package fsd_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int WID_W      = 12;
   localparam int HGT_W      = 16;
   localparam int GRAY_W     = 8;
   localparam int ERR_W      = 12;
   localparam int SUM_W      = ERR_W + 2;
   localparam int PROD_W     = ERR_W + 3;
   localparam int BANK_DEPTH = MAX_WIDTH / 2;
   localparam int BANK_AW    = COL_W - 1;
   localparam int CSR_DATA_W = 16;

   localparam int SAT_LIMIT       = 2047;
   localparam int WHITE_THRESHOLD = 128;
   localparam int WHITE_LEVEL     = 255;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // One write into the line store.
   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      logic [ERR_W-1:0] data;
   } lst_wr_type;

endpackage

// ===== sv/fsd_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dither stream interfaces
// Valid/ready channels for the gray pixel requests and the dither results.
// ---------------------------------------------------------------------------
interface fsd_req_if;
   import fsd_pkg::*;

   logic              valid;
   logic              ready;
   logic [GRAY_W-1:0] gray_level;

   modport source (output valid, output gray_level, input ready);
   modport sink   (input valid, input gray_level, output ready);
endinterface

interface fsd_rsp_if;
   logic valid;
   logic ready;
   logic white_pixel;
   logic end_of_row;
   logic end_of_frame;

   modport source (output valid, output white_pixel, output end_of_row,
                   output end_of_frame, input ready);
   modport sink   (input valid, input white_pixel, input end_of_row,
                   input end_of_frame, output ready);
endinterface

// ===== sv/fsd_line_store.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dither line store
// Error terms for the next row, kept in an even and an odd column bank so
// that two neighbouring columns can be written in the same cycle. Cleared after
// reset by a sweep over both banks.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fsd_line_store (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [fsd_pkg::COL_W-1:0] rd_addr,
   input  fsd_pkg::lst_wr_type      wr_a,
   input  fsd_pkg::lst_wr_type      wr_b,
   output logic [fsd_pkg::ERR_W-1:0] rd_data,
   output logic                     clear_done
);
   import fsd_pkg::*;

   logic [ERR_W-1:0]   mem_even [BANK_DEPTH];
   logic [ERR_W-1:0]   mem_odd  [BANK_DEPTH];
   logic [ERR_W-1:0]   rd_even_ff;
   logic [ERR_W-1:0]   rd_odd_ff;
   logic               rd_par_ff;
   logic               clr_busy_ff;
   logic [BANK_AW-1:0] clr_cnt_ff;

   logic               ev_we;
   logic [BANK_AW-1:0] ev_addr;
   logic [ERR_W-1:0]   ev_data;
   logic               od_we;
   logic [BANK_AW-1:0] od_addr;
   logic [ERR_W-1:0]   od_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == BANK_AW'(BANK_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   assign clear_done = !clr_busy_ff;

   // The two writes of one cycle always fall on columns of opposite parity.
   always_comb begin
      ev_we   = 1'b0;
      ev_addr = clr_cnt_ff;
      ev_data = '0;
      od_we   = 1'b0;
      od_addr = clr_cnt_ff;
      od_data = '0;
      if (clr_busy_ff) begin
         ev_we = 1'b1;
         od_we = 1'b1;
      end else begin
         if (wr_a.en && !wr_a.addr[0]) begin
            ev_we   = 1'b1;
            ev_addr = wr_a.addr[COL_W-1:1];
            ev_data = wr_a.data;
         end else if (wr_b.en && !wr_b.addr[0]) begin
            ev_we   = 1'b1;
            ev_addr = wr_b.addr[COL_W-1:1];
            ev_data = wr_b.data;
         end
         if (wr_a.en && wr_a.addr[0]) begin
            od_we   = 1'b1;
            od_addr = wr_a.addr[COL_W-1:1];
            od_data = wr_a.data;
         end else if (wr_b.en && wr_b.addr[0]) begin
            od_we   = 1'b1;
            od_addr = wr_b.addr[COL_W-1:1];
            od_data = wr_b.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ev_we) begin
         mem_even[ev_addr] <= ev_data;
      end
      if (rd_en) begin
         rd_even_ff <= mem_even[rd_addr[COL_W-1:1]];
      end
   end

   always_ff @(posedge clock) begin
      if (od_we) begin
         mem_odd[od_addr] <= od_data;
      end
      if (rd_en) begin
         rd_odd_ff <= mem_odd[rd_addr[COL_W-1:1]];
         rd_par_ff <= rd_addr[0];
      end
   end

   assign rd_data = rd_par_ff ? rd_odd_ff : rd_even_ff;

   `ASSERT_IMPLIES(a_split_banks, clock, reset, wr_a.en && wr_b.en, wr_a.addr[0] != wr_b.addr[0])
   `ASSERT_IMPLIES(a_no_write_in_clear, clock, reset, clr_busy_ff, !wr_a.en && !wr_b.en && !rd_en)
   `ASSERT_NEXT(a_clear_ends, clock, reset, clr_busy_ff && (clr_cnt_ff == BANK_AW'(BANK_DEPTH - 1)), !clr_busy_ff)

endmodule

// ===== sv/floyd_steinberg_binary_dither.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Floyd-Steinberg binary dither
// Pipeline: an accepted request is held in the input register, and its
// result is written to the result register once the output can take it.
// Throughput: one pixel per cycle while the output is not stalled, set by
// the error update between consecutive pixels of a row.
// Reset: the line store is swept to zero after reset, during which no
// request is accepted; configuration writes are taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module floyd_steinberg_binary_dither (
   input  logic                           clock,
   input  logic                           reset,
   fsd_req_if.sink                        req_bus,
   fsd_rsp_if.source                      rsp_bus,
   input  logic                           csr_we,
   input  fsd_pkg::csr_index_type         csr_addr,
   input  logic [fsd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fsd_pkg::*;

   // Configuration
   logic [WID_W-1:0] width_ff;
   logic [HGT_W-1:0] height_ff;
   logic [WID_W-1:0] w_eff;
   logic [WID_W-1:0] w_m1;
   logic [HGT_W-1:0] h_eff;

   // Position of the next request
   logic [COL_W-1:0] col_ff, col_in;
   logic [HGT_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] x_in;
   logic             last_col_in;
   logic             last_row_in;

   // Input register
   logic              s1_v_ff;
   logic [GRAY_W-1:0] s1_gray_ff;
   logic [COL_W-1:0]  s1_x_ff;
   logic              s1_last_col_ff;
   logic              s1_last_row_ff;
   logic              fwd_v_ff;
   logic [ERR_W-1:0]  fwd_data_ff;

   // Diffusion state
   logic signed [ERR_W-1:0] etr_ff, etr_in;
   logic signed [ERR_W-1:0] pbl_ff, pbl_in;
   logic signed [ERR_W-1:0] pb_ff, pb_in;

   // Result register
   logic out_v_ff;
   logic out_white_ff;
   logic out_eor_ff;
   logic out_eof_ff;

   logic accept;
   logic fire;
   logic clear_done;
   logic hit_a;
   logic hit_b;

   logic [ERR_W-1:0]         rd_data;
   logic signed [ERR_W-1:0]  below;
   logic signed [SUM_W-1:0]  sum;
   logic signed [ERR_W-1:0]  corr;
   logic                     white;
   logic signed [ERR_W-1:0]  err;
   logic signed [PROD_W-1:0] ex, e3, e5, e7;
   logic signed [ERR_W-1:0]  t1, t3, t5, t7;
   logic signed [ERR_W-1:0]  below_sum;

   lst_wr_type wr_a;
   lst_wr_type wr_b;

   // -----------------------------------------------------------------------
   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WID_W'(640);
         height_ff <= HGT_W'(480);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[WID_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[HGT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WID_W'(1);
      end else if (width_ff > WID_W'(MAX_WIDTH)) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff == '0) ? HGT_W'(1) : height_ff;
      w_m1  = w_eff - WID_W'(1);
   end

   // -----------------------------------------------------------------------
   // Handshake
   assign fire          = s1_v_ff && (!out_v_ff || rsp_bus.ready);
   assign req_bus.ready = clear_done && (!s1_v_ff || fire);
   assign accept        = req_bus.valid && req_bus.ready;

   // -----------------------------------------------------------------------
   // Column and row of the incoming request. A column left past the width by
   // a narrower setting counts as the last one.
   always_comb begin
      x_in        = ({1'b0, col_ff} >= w_eff) ? w_m1[COL_W-1:0] : col_ff;
      last_col_in = ({1'b0, x_in} + WID_W'(1)) >= w_eff;
      last_row_in = ({1'b0, row_ff} + 17'd1) >= {1'b0, h_eff};
      col_in      = last_col_in ? '0 : x_in + 1'b1;
      if (!last_col_in) begin
         row_in = row_ff;
      end else if (last_row_in) begin
         row_in = '0;
      end else begin
         row_in = row_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // The line store read is issued as the request is taken. A write to the
   // same column by the pixel finishing in that cycle is forwarded instead.
   assign hit_a = wr_a.en && (wr_a.addr == x_in);
   assign hit_b = wr_b.en && (wr_b.addr == x_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (accept) begin
         s1_v_ff <= 1'b1;
      end else if (fire) begin
         s1_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_gray_ff     <= req_bus.gray_level;
         s1_x_ff        <= x_in;
         s1_last_col_ff <= last_col_in;
         s1_last_row_ff <= last_row_in;
         fwd_v_ff       <= hit_a || hit_b;
         fwd_data_ff    <= hit_a ? wr_a.data : wr_b.data;
      end
   end

   fsd_line_store u_line_store (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_addr    (x_in),
      .wr_a       (wr_a),
      .wr_b       (wr_b),
      .rd_data    (rd_data),
      .clear_done (clear_done)
   );

   // -----------------------------------------------------------------------
   // Threshold and error diffusion
   always_comb begin
      below = signed'(fwd_v_ff ? fwd_data_ff : rd_data);
      sum   = signed'({{(SUM_W-GRAY_W){1'b0}}, s1_gray_ff})
            + SUM_W'(etr_ff) + SUM_W'(below);
      if (sum > SUM_W'(SAT_LIMIT)) begin
         corr = ERR_W'(SAT_LIMIT);
      end else if (sum < -SUM_W'(SAT_LIMIT)) begin
         corr = -ERR_W'(SAT_LIMIT);
      end else begin
         corr = sum[ERR_W-1:0];
      end
      white = corr > ERR_W'(WHITE_THRESHOLD);
      err   = white ? (corr - ERR_W'(WHITE_LEVEL)) : corr;

      // Dropping the low four bits of a two's complement value floors it.
      ex = PROD_W'(err);
      e3 = ex + (ex <<< 1);
      e5 = ex + (ex <<< 2);
      e7 = (ex <<< 3) - ex;
      t1 = {{4{err[ERR_W-1]}}, err[ERR_W-1:4]};
      t3 = {e3[PROD_W-1], e3[PROD_W-1:4]};
      t5 = {e5[PROD_W-1], e5[PROD_W-1:4]};
      t7 = {e7[PROD_W-1], e7[PROD_W-1:4]};

      below_sum = pb_ff + t5;
      pbl_in    = s1_last_col_ff ? '0 : below_sum;
      pb_in     = s1_last_col_ff ? '0 : t1;
      etr_in    = s1_last_col_ff ? '0 : t7;

      // Column left of this one in the next row is now complete.
      wr_a.en   = fire && (s1_x_ff != '0);
      wr_a.addr = s1_x_ff - 1'b1;
      wr_a.data = s1_last_row_ff ? '0 : (pbl_ff + t3);
      // At the end of a row this column is complete as well.
      wr_b.en   = fire && s1_last_col_ff;
      wr_b.addr = s1_x_ff;
      wr_b.data = s1_last_row_ff ? '0 : below_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         etr_ff <= '0;
         pbl_ff <= '0;
         pb_ff  <= '0;
      end else if (fire) begin
         etr_ff <= etr_in;
         pbl_ff <= pbl_in;
         pb_ff  <= pb_in;
      end
   end

   // -----------------------------------------------------------------------
   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (fire) begin
         out_v_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_white_ff <= white;
         out_eor_ff   <= s1_last_col_ff;
         out_eof_ff   <= s1_last_col_ff && s1_last_row_ff;
      end
   end

   assign rsp_bus.valid        = out_v_ff;
   assign rsp_bus.white_pixel  = out_white_ff;
   assign rsp_bus.end_of_row   = out_eor_ff;
   assign rsp_bus.end_of_frame = out_eof_ff;

   `ASSERT_NEXT(a_s1_holds, clock, reset, s1_v_ff && !fire, s1_v_ff)
   `ASSERT_IMPLIES(a_eof_ends_row, clock, reset, out_v_ff && out_eof_ff, out_eor_ff)
   `ASSERT_NEXT(a_row_end_clears, clock, reset, fire && s1_last_col_ff, (etr_ff == '0) && (pb_ff == '0) && (pbl_ff == '0))
   `ASSERT_IMPLIES(a_no_req_in_clear, clock, reset, !clear_done, !accept && !s1_v_ff)

endmodule
